// ===== src/ptc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, widths and helpers for the pressure and temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int RawW     = 20;
  localparam int CalTempW = 48;
  localparam int CalW     = 64;
  localparam int CalCW    = 16;
  localparam int OutW     = 32;
  localparam int DivW     = 64;
  localparam int CfgIdxW  = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAL_TEMP    = 2'd0,
    CFG_CAL_PRESS_A = 2'd1,
    CFG_CAL_PRESS_B = 2'd2,
    CFG_CAL_PRESS_C = 2'd3
  } cfg_idx_e;

  // temperature results carried down the pipeline
  typedef struct packed {
    logic [OutW-1:0] tc;
    logic [OutW-1:0] fine;
  } ptc_temp_t;

  // sideband through the divider and the pressure tail
  typedef struct packed {
    ptc_temp_t temp;
    logic      ok;
    logic      neg;
  } ptc_side_t;

  // partial products of a 64-bit pattern times a 17-bit signed factor
  typedef struct packed {
    logic [49:0] lo;
    logic [31:0] hi;
  } ptc_part_t;

  // low and high halves multiplied separately, summed in a later stage
  function automatic ptc_part_t mul_part(logic [63:0] x, logic [16:0] c);
    ptc_part_t          r;
    logic signed [49:0] lo;
    logic [31:0]        hw;
    lo   = $signed({1'b0, x[31:0]}) * $signed(c);
    // high half against the factor sign-extended, low 32 bits only
    hw   = x[63:32] * {{15{c[16]}}, c};
    r.lo = lo;
    r.hi = hw;
    return r;
  endfunction

  // low 64 bits of the full product
  function automatic logic [63:0] mul_comb(ptc_part_t p);
    return {{14{p.lo[49]}}, p.lo} + {p.hi, 32'h0};
  endfunction

endpackage

// ===== src/pressure_temp_compensation_unit.sv =====
`timescale 1ns / 1ps
// The pipe has 12 prep stages, 64 divider stages and 7 tail stages between input
// beat and result. Throughput: one beat per cycle; the 64-stage
// quotient pipeline sets the depth. A held result stalls the whole pipe.
// Reset clears all stage valid bits and the calibration registers to zero.
// ----------------------------------------------------------------------------
// pressure_temp_compensation_unit
// Integer 64-bit temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ptc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ptc_pkg::CalW-1:0]     cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // raw_temp [19:0], raw_press [39:20]
  input  logic [39:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // temp_centi [31:0], fine_temp [63:32], press_q24_8 [95:64]
  output logic [95:0]                  m_axis_tdata,
  // press_valid [0]
  output logic                         m_axis_tuser
);
  import ptc_pkg::*;

  localparam int PreN  = 12;
  localparam int PostN = 7;

  logic [CalTempW-1:0] cal_temp_q;
  logic [CalW-1:0]     cal_press_a_q, cal_press_b_q;
  logic [CalCW-1:0]    cal_press_c_q;

  // calibration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q    <= '0;
      cal_press_a_q <= '0;
      cal_press_b_q <= '0;
      cal_press_c_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CAL_TEMP:    cal_temp_q    <= cfg_wdata_i[CalTempW-1:0];
        CFG_CAL_PRESS_A: cal_press_a_q <= cfg_wdata_i;
        CFG_CAL_PRESS_B: cal_press_b_q <= cfg_wdata_i;
        CFG_CAL_PRESS_C: cal_press_c_q <= cfg_wdata_i[CalCW-1:0];
        default: ;
      endcase
    end
  end

  // coefficient fields
  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = cal_temp_q[15:0];
  assign t2 = cal_temp_q[31:16];
  assign t3 = cal_temp_q[47:32];
  assign p1 = cal_press_a_q[15:0];
  assign p2 = cal_press_a_q[31:16];
  assign p3 = cal_press_a_q[47:32];
  assign p4 = cal_press_a_q[63:48];
  assign p5 = cal_press_b_q[15:0];
  assign p6 = cal_press_b_q[31:16];
  assign p7 = cal_press_b_q[47:32];
  assign p8 = cal_press_b_q[63:48];
  assign p9 = cal_press_c_q;

  // global advance: the output slot is free or being taken
  logic en, accept;
  logic [PreN-1:0]  pre_vld_q;
  logic [PostN-1:0] post_vld_q;
  logic             div_vld;

  assign en            = !post_vld_q[PostN-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q  <= '0;
      post_vld_q <= '0;
    end else if (en) begin
      pre_vld_q  <= {pre_vld_q[PreN-2:0], accept};
      post_vld_q <= {post_vld_q[PostN-2:0], div_vld};
    end
  end

  logic [RawW-1:0] raw_t, raw_p;
  assign raw_t = s_axis_tdata[RawW-1:0];
  assign raw_p = s_axis_tdata[2*RawW-1:RawW];

  // stage 1: temperature differences and first products
  logic signed [17:0] x1;
  logic signed [16:0] dt;
  logic signed [33:0] s1_ma_q, s1_mdd_q;
  logic [RawW-1:0]    s1_adp_q;
  assign x1 = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dt = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, t1});

  // stage 2
  logic [31:0]        s2_a_q;
  logic signed [31:0] dsh;
  logic signed [47:0] s2_mb_q;
  logic [RawW-1:0]    s2_adp_q;
  assign dsh = $signed(s1_mdd_q[31:0]) >>> 12;

  // stage 3: fine temperature
  logic [31:0]     s3_fine_q;
  logic [31:0]     tb;
  logic [RawW-1:0] s3_adp_q;
  assign tb = 32'($signed(s2_mb_q[31:0]) >>> 14);

  // stage 4: centi-degrees and pressure offset term
  logic [31:0]        tcw;
  ptc_temp_t          s4_temp_q;
  logic signed [32:0] s4_v1_q;
  logic [RawW-1:0]    s4_adp_q;
  assign tcw = s3_fine_q * 32'd5 + 32'd128;

  // stage 5: products of the offset term
  logic signed [65:0] vsq;
  logic [63:0]        s5_vv_q;
  logic signed [48:0] s5_p5m_q, s5_p2m_q;
  ptc_temp_t          s5_temp_q;
  logic [RawW-1:0]    s5_adp_q;
  assign vsq = s4_v1_q * s4_v1_q;

  // stage 6: partial products against p6 and p3
  ptc_part_t          s6_part6_q, s6_part3_q;
  logic signed [48:0] s6_p5m_q, s6_p2m_q;
  ptc_temp_t          s6_temp_q;
  logic [RawW-1:0]    s6_adp_q;

  // stage 7
  logic [63:0]        s7_vvp6_q, s7_vvp3_q;
  logic signed [48:0] s7_p5m_q, s7_p2m_q;
  ptc_temp_t          s7_temp_q;
  logic [RawW-1:0]    s7_adp_q;

  // stage 8: var2 and var1 sums
  logic [63:0]     p5term, p4term, p2term;
  logic [63:0]     s8_v2_q, s8_v1b_q;
  ptc_temp_t       s8_temp_q;
  logic [RawW-1:0] s8_adp_q;
  assign p5term = {{15{s7_p5m_q[48]}}, s7_p5m_q} << 17;
  assign p4term = {{48{p4[15]}}, p4} << 35;
  assign p2term = {{15{s7_p2m_q[48]}}, s7_p2m_q} << 12;

  // stage 9: divisor base and dividend base
  logic [20:0]     pr21;
  logic [63:0]     s9_w_q, s9_num0_q;
  ptc_temp_t       s9_temp_q;
  assign pr21 = 21'h100000 - {1'b0, s8_adp_q};

  // stage 10: partial products against p1 and the scale constant
  ptc_part_t s10_partw_q, s10_partn_q;
  ptc_temp_t s10_temp_q;

  // stage 11
  logic [63:0] s11_wp1_q, s11_num_q;
  ptc_temp_t   s11_temp_q;

  // stage 12: signs and magnitudes for the divider
  logic [63:0] dv, an, ad;
  logic [63:0] s12_an_q, s12_ad_q;
  ptc_side_t   s12_side_q;
  assign dv = 64'($signed(s11_wp1_q) >>> 33);
  assign an = s11_num_q[63] ? 64'(0 - s11_num_q) : s11_num_q;
  assign ad = dv[63] ? 64'(0 - dv) : dv;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ma_q     <= x1 * $signed(t2);
      s1_mdd_q    <= dt * dt;
      s1_adp_q    <= raw_p;

      s2_a_q      <= 32'($signed(s1_ma_q[31:0]) >>> 11);
      s2_mb_q     <= dsh * $signed(t3);
      s2_adp_q    <= s1_adp_q;

      s3_fine_q   <= s2_a_q + tb;
      s3_adp_q    <= s2_adp_q;

      s4_temp_q.tc   <= 32'($signed(tcw) >>> 8);
      s4_temp_q.fine <= s3_fine_q;
      s4_v1_q     <= $signed({s3_fine_q[31], s3_fine_q}) - 33'sd128000;
      s4_adp_q    <= s3_adp_q;

      s5_vv_q     <= vsq[63:0];
      s5_p5m_q    <= s4_v1_q * $signed(p5);
      s5_p2m_q    <= s4_v1_q * $signed(p2);
      s5_temp_q   <= s4_temp_q;
      s5_adp_q    <= s4_adp_q;

      s6_part6_q  <= mul_part(s5_vv_q, {p6[15], p6});
      s6_part3_q  <= mul_part(s5_vv_q, {p3[15], p3});
      s6_p5m_q    <= s5_p5m_q;
      s6_p2m_q    <= s5_p2m_q;
      s6_temp_q   <= s5_temp_q;
      s6_adp_q    <= s5_adp_q;

      s7_vvp6_q   <= mul_comb(s6_part6_q);
      s7_vvp3_q   <= mul_comb(s6_part3_q);
      s7_p5m_q    <= s6_p5m_q;
      s7_p2m_q    <= s6_p2m_q;
      s7_temp_q   <= s6_temp_q;
      s7_adp_q    <= s6_adp_q;

      s8_v2_q     <= s7_vvp6_q + p5term + p4term;
      s8_v1b_q    <= 64'($signed(s7_vvp3_q) >>> 8) + p2term;
      s8_temp_q   <= s7_temp_q;
      s8_adp_q    <= s7_adp_q;

      s9_w_q      <= 64'h0000_8000_0000_0000 + s8_v1b_q;
      s9_num0_q   <= ({43'h0, pr21} << 31) - s8_v2_q;
      s9_temp_q   <= s8_temp_q;

      s10_partw_q <= mul_part(s9_w_q, {1'b0, p1});
      s10_partn_q <= mul_part(s9_num0_q, 17'd3125);
      s10_temp_q  <= s9_temp_q;

      s11_wp1_q   <= mul_comb(s10_partw_q);
      s11_num_q   <= mul_comb(s10_partn_q);
      s11_temp_q  <= s10_temp_q;

      s12_an_q        <= an;
      s12_ad_q        <= ad;
      s12_side_q.temp <= s11_temp_q;
      s12_side_q.ok   <= (dv != 64'h0);
      s12_side_q.neg  <= s11_num_q[63] ^ dv[63];
    end
  end

  // quotient pipeline
  logic [DivW-1:0] div_q;
  ptc_side_t       div_side;

  ptc_div #(
    .Width (DivW),
    .SideW ($bits(ptc_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pre_vld_q[PreN-1]),
    .num_i   (s12_an_q),
    .den_i   (s12_ad_q),
    .side_i  (s12_side_q),
    .valid_o (div_vld),
    .quo_o   (div_q),
    .side_o  (div_side)
  );

  // tail stage 1: signed quotient
  logic [63:0] q1_p_q;
  ptc_side_t   q1_side_q;

  // tail stage 2: square and p8 partials
  logic [63:0] psh;
  logic [63:0] q2_sqlo_q, q2_p_q;
  logic [63:0] crossw;
  logic [31:0] q2_cross_q;
  ptc_part_t   q2_part8_q;
  ptc_side_t   q2_side_q;
  assign psh    = 64'($signed(q1_p_q) >>> 13);
  assign crossw = psh[31:0] * psh[63:32];

  // tail stage 3
  logic [63:0] q3_sq_q, q3_p8p_q, q3_p_q;
  ptc_side_t   q3_side_q;

  // tail stage 4
  ptc_part_t   q4_part9_q;
  logic [63:0] q4_v2_q, q4_p_q;
  ptc_side_t   q4_side_q;

  // tail stage 5
  logic [63:0] q5_v1_q, q5_v2_q, q5_p_q;
  ptc_side_t   q5_side_q;

  // tail stage 6
  logic [63:0] q6_s_q;
  ptc_side_t   q6_side_q;

  // tail stage 7: final offset and saturation
  logic [63:0] rfin;
  logic [31:0] press;
  logic [31:0] q7_press_q;
  ptc_side_t   q7_side_q;
  assign rfin = 64'($signed(q6_s_q) >>> 8) + ({{48{p7[15]}}, p7} << 4);

  always_comb begin
    if (!q6_side_q.ok || rfin[63]) begin
      press = 32'h0;
    end else if (|rfin[63:32]) begin
      press = 32'hFFFF_FFFF;
    end else begin
      press = rfin[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_p_q     <= div_side.neg ? 64'(0 - div_q) : div_q;
      q1_side_q  <= div_side;

      q2_sqlo_q  <= psh[31:0] * psh[31:0];
      q2_cross_q <= crossw[31:0];
      q2_part8_q <= mul_part(q1_p_q, {p8[15], p8});
      q2_p_q     <= q1_p_q;
      q2_side_q  <= q1_side_q;

      q3_sq_q    <= q2_sqlo_q + {q2_cross_q[30:0], 1'b0, 32'h0};
      q3_p8p_q   <= mul_comb(q2_part8_q);
      q3_p_q     <= q2_p_q;
      q3_side_q  <= q2_side_q;

      q4_part9_q <= mul_part(q3_sq_q, {p9[15], p9});
      q4_v2_q    <= 64'($signed(q3_p8p_q) >>> 19);
      q4_p_q     <= q3_p_q;
      q4_side_q  <= q3_side_q;

      q5_v1_q    <= 64'($signed(mul_comb(q4_part9_q)) >>> 25);
      q5_v2_q    <= q4_v2_q;
      q5_p_q     <= q4_p_q;
      q5_side_q  <= q4_side_q;

      q6_s_q     <= q5_p_q + q5_v1_q + q5_v2_q;
      q6_side_q  <= q5_side_q;

      q7_press_q <= press;
      q7_side_q  <= q6_side_q;
    end
  end

  // result beat
  assign m_axis_tvalid = post_vld_q[PostN-1];
  assign m_axis_tdata  = {q7_press_q, q7_side_q.temp.fine, q7_side_q.temp.tc};
  assign m_axis_tuser  = q7_side_q.ok;

endmodule

// ===== src/ptc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined restoring divider for unsigned operands, one quotient bit per
// stage, with a sideband word carried alongside each beat.
// ----------------------------------------------------------------------------
module ptc_div #(
  parameter int Width = 64,
  parameter int SideW = 66
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [Width-1:0] num_i,
  input  logic [Width-1:0] den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [Width-1:0] quo_o,
  output logic [SideW-1:0] side_o
);

  logic [Width-1:0] rem_q  [Width];
  logic [Width-1:0] nq_q   [Width];
  logic [Width-1:0] den_q  [Width];
  logic [SideW-1:0] side_q [Width];
  logic             vld_q  [Width];

  for (genvar k = 0; k < Width; k++) begin : g_stage
    logic [Width-1:0] rem_p, nq_p, den_p;
    logic [SideW-1:0] side_p;
    logic             vld_p;
    logic [Width:0]   trial;
    logic             qb;

    // previous stage, or the inputs for the first one
    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign nq_p   = num_i;
      assign den_p  = den_i;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign nq_p   = nq_q[k-1];
      assign den_p  = den_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    // shift in next dividend bit and trial subtract
    assign trial = {rem_p, nq_p[Width-1]} - {1'b0, den_p};
    assign qb    = ~trial[Width];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= qb ? trial[Width-1:0] : {rem_p[Width-2:0], nq_p[Width-1]};
        nq_q[k]   <= {nq_p[Width-2:0], qb};
        den_q[k]  <= den_p;
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[Width-1];
  assign quo_o   = nq_q[Width-1];
  assign side_o  = side_q[Width-1];

endmodule

// ===== tb/tb_pressure_temp_compensation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pressure_temp_compensation_unit
// Streams raw temperature and pressure pairs through the compensation unit
// under several calibration sets and checks every result beat against an
// in-bench integer model of the compensation, with random stalls both sides.
// ----------------------------------------------------------------------------
module tb_pressure_temp_compensation_unit;
  import ptc_pkg::*;

  localparam int Latency  = 83;
  localparam int MaxCycle = 400000;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } reading_t;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] fine_temp;
    logic [31:0] press;
    logic        press_ok;
  } comp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CalW-1:0]    cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;

  pressure_temp_compensation_unit i_dut (.*);

  // calibration shadow
  logic [47:0] cal_temp_q = '0;
  logic [63:0] cal_a_q = '0, cal_b_q = '0;
  logic [15:0] cal_c_q = '0;

  reading_t pending_q[$];
  comp_t    expected_q[$];
  int       err_cnt = 0;
  int       cycle_cnt = 0;
  bit       no_idle = 1'b0;
  bit       in_acc_q = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // signed 16-bit field sign-extended to 64 bits
  function automatic logic signed [63:0] coef(logic [63:0] r, int sh);
    logic [15:0] v;
    v = 16'(r >> sh);
    return {{48{v[15]}}, v};
  endfunction

  function automatic comp_t compensate(reading_t rd);
    comp_t r;
    logic signed [31:0] t1, t2, t3, a, d, b, fine;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, p, n, q;
    logic [63:0] an, ad;
    t1 = {16'h0, cal_temp_q[15:0]};
    t2 = 32'(coef(cal_temp_q, 16));
    t3 = 32'(coef(cal_temp_q, 32));
    p1 = {48'h0, cal_a_q[15:0]};
    p2 = coef(cal_a_q, 16); p3 = coef(cal_a_q, 32); p4 = coef(cal_a_q, 48);
    p5 = coef(cal_b_q, 0);  p6 = coef(cal_b_q, 16);
    p7 = coef(cal_b_q, 32); p8 = coef(cal_b_q, 48);
    p9 = coef({48'h0, cal_c_q}, 0);
    a = ((($signed({12'h0, rd.raw_temp}) >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d = ($signed({12'h0, rd.raw_temp}) >>> 4) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    fine = a + b;
    r.fine_temp = fine;
    r.temp_centi = (fine * 32'sd5 + 32'sd128) >>> 8;
    v1 = 64'(fine) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      r.press = '0;
      r.press_ok = 1'b0;
    end else begin
      p = 64'sd1048576 - $signed({44'h0, rd.raw_press});
      n = ((p <<< 31) - v2) * 64'sd3125;
      // truncating division on magnitudes, wraps for most negative / -1
      an = n[63] ? -n : n;
      ad = v1[63] ? -v1 : v1;
      q = an / ad;
      p = (n[63] != v1[63]) ? -q : q;
      v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
      if (p[63]) r.press = '0;
      else if (p[62:32] != 0) r.press = 32'hFFFF_FFFF;
      else r.press = p[31:0];
      r.press_ok = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  // input handshake as seen at the rising edge
  always @(posedge clk_i) begin
    in_acc_q <= s_axis_tvalid && s_axis_tready;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc_q) begin
        expected_q.push_back(compensate(pending_q.pop_front()));
      end
      if (in_acc_q || !s_axis_tvalid) begin
        if (pending_q.size() > 0 && (no_idle || $urandom_range(99) >= 18)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pending_q[0].raw_press, pending_q[0].raw_temp};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 18);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    comp_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata[31:0], '0);
      end else begin
        w = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== w.temp_centi)
          report_mismatch("temp_centi", m_axis_tdata[31:0], w.temp_centi);
        if (m_axis_tdata[63:32] !== w.fine_temp)
          report_mismatch("fine_temp", m_axis_tdata[63:32], w.fine_temp);
        if (m_axis_tdata[95:64] !== w.press)
          report_mismatch("press_q24_8", m_axis_tdata[95:64], w.press);
        if (m_axis_tuser !== w.press_ok)
          report_mismatch("press_valid", {31'h0, m_axis_tuser}, {31'h0, w.press_ok});
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycle) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_cal(cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_CAL_TEMP:    cal_temp_q = val[47:0];
      CFG_CAL_PRESS_A: cal_a_q = val;
      CFG_CAL_PRESS_B: cal_b_q = val;
      default:         cal_c_q = val[15:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait for the pipe to drain before touching the calibration
  task automatic drain();
    wait (pending_q.size() == 0 && !s_axis_tvalid && expected_q.size() == 0);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  task automatic add_readings(int cnt);
    reading_t rd;
    for (int i = 0; i < cnt; i++) begin
      rd.raw_temp  = 20'($urandom);
      rd.raw_press = 20'($urandom);
      case ($urandom_range(7))
        0: rd.raw_temp = $urandom_range(1) ? 20'hFFFFF : 20'h0;
        1: rd.raw_press = $urandom_range(1) ? 20'hFFFFF : 20'h0;
        2: begin
          // typical sensor range
          rd.raw_temp  = 20'($urandom_range(20'h8C000, 20'h7A000));
          rd.raw_press = 20'($urandom_range(20'h70000, 20'h50000));
        end
        default: ;
      endcase
      pending_q.push_back(rd);
    end
  endtask

  task automatic load_set(int kind);
    case (kind)
      0: begin
        // typical datasheet-like coefficients
        write_cal(CFG_CAL_TEMP, 64'({16'hFFE8, 16'h6778, 16'h6C70}));
        write_cal(CFG_CAL_PRESS_A, {16'h2710, 16'h0BD0, 16'hD5A4, 16'h8E3C});
        write_cal(CFG_CAL_PRESS_B, {16'h3C70, 16'hC5F8, 16'hFFF9, 16'h008C});
        write_cal(CFG_CAL_PRESS_C, 64'h1770);
      end
      1: begin
        write_cal(CFG_CAL_TEMP, '1);
        write_cal(CFG_CAL_PRESS_A, '1);
        write_cal(CFG_CAL_PRESS_B, '1);
        write_cal(CFG_CAL_PRESS_C, '1);
      end
      2: begin
        write_cal(CFG_CAL_TEMP, 64'({16'h8000, 16'h7FFF, 16'hFFFF}));
        write_cal(CFG_CAL_PRESS_A, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
        write_cal(CFG_CAL_PRESS_B, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        write_cal(CFG_CAL_PRESS_C, 64'h8000);
      end
      3: begin
        // p1 zero forces the zero-divisor path
        write_cal(CFG_CAL_PRESS_A, {$urandom, $urandom} & ~64'hFFFF);
      end
      default: begin
        write_cal(CFG_CAL_TEMP, {$urandom, $urandom});
        write_cal(CFG_CAL_PRESS_A, {$urandom, $urandom});
        write_cal(CFG_CAL_PRESS_B, {$urandom, $urandom});
        write_cal(CFG_CAL_PRESS_C, {$urandom, $urandom});
      end
    endcase
  endtask

  initial begin
    reading_t rd;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: all-zero calibration gives zero divisor
    rd = '0; pending_q.push_back(rd);
    rd = '1; pending_q.push_back(rd);
    drain();
    load_set(0);
    rd = '{20'h0, 20'h0};         pending_q.push_back(rd);
    rd = '{20'hFFFFF, 20'hFFFFF}; pending_q.push_back(rd);
    rd = '{20'h0, 20'hFFFFF};     pending_q.push_back(rd);
    rd = '{20'hFFFFF, 20'h0};     pending_q.push_back(rd);
    rd = '{20'h7E8F0, 20'h65A30}; pending_q.push_back(rd);
    rd = '{20'h80000, 20'h80000}; pending_q.push_back(rd);
    drain();
    for (int k = 1; k <= 3; k++) begin
      load_set(k);
      add_readings(6);
      drain();
    end
    // random phases over several calibration sets
    for (int ph = 0; ph < 12; ph++) begin
      load_set(ph == 0 ? 0 : (ph < 4 ? ph : 4 + (ph % 2)));
      no_idle = (ph == 6);
      add_readings(155);
      drain();
    end
    no_idle = 1'b0;
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ptc_pkg.sv
src/ptc_div.sv
src/pressure_temp_compensation_unit.sv
tb/tb_pressure_temp_compensation_unit.sv
